>>> hdl/lmsd_pkg.sv
// Shared types and constants for the LED matrix scan driver.
// No dependencies; imported by led_matrix_scan_driver.
`timescale 1ns / 1ps
`default_nettype none

package lmsd_pkg;

	// Fixed field widths
	localparam int unsigned OPC_W  = 2;
	localparam int unsigned IDX_W  = 7;
	localparam int unsigned LINE_W = 10;
	// Width for LED counts and positions, covers up to 16 x 16 LEDs
	localparam int unsigned WIDE_W = 9;
	localparam int unsigned ROW_W  = 4;

	typedef enum logic [OPC_W-1:0] {
		OP_SET  = 2'd0,
		OP_FILL = 2'd1,
		OP_TICK = 2'd2
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_FILL = 1'b1
	} state_t;

endpackage

`default_nettype wire

>>> hdl/led_matrix_scan_driver.sv
// Top level of the LED matrix scan driver: frame store, fill sequencer, scan logic.
// Depends on lmsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Multiplexed ROWS x COLUMNS LED matrix driver. Each input beat carries an
// opcode: set one LED (index, status), fill LEDs 0 to index-1 with status,
// or a scan tick. LED n sits at row n / COLUMNS, column n % COLUMNS. Ticks
// alternate a blanking phase (columns off, row select kept) and a drive
// phase (one-hot row select, columns of that row from the store, row
// advances modulo ROWS). Every tick yields one result beat with the line
// state after it; writes yield none. A fill writes
// ceil(min(index, ROWS*COLUMNS) / COLUMNS) frame rows, one per cycle
// through a shared subtractor that turns the remaining count into a
// column mask; item_stall is high while those rows are written.
// A fill of zero writes no row. A tick also stalls while the previous
// result beat is still held on the output; writes pass. The frame store
// is cleared by reset, with no clearing pass.
module led_matrix_scan_driver
	import lmsd_pkg::*;
#(
	parameter int unsigned ROWS    = 10,
	parameter int unsigned COLUMNS = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input beats
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire logic [OPC_W-1:0]  opcode,
	input  wire logic [IDX_W-1:0]  index,
	input  wire logic              status,
	// result beats
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic [LINE_W-1:0]      row_select,
	output logic [LINE_W-1:0]      column_drive
);

	localparam int unsigned LED_COUNT = ROWS * COLUMNS;

	// Frame store, one flip-flop per LED
	logic [LED_COUNT-1:0] frame_q;

	// Scan state
	logic [ROW_W-1:0]   scan_row_q;
	logic               scan_phase_q;   // 0: blanking next, 1: drive next
	logic [ROWS-1:0]    row_lines_q;
	logic [COLUMNS-1:0] column_lines_q;
	logic               result_valid_q;

	// Fill sequencer
	state_t             state_q, state_d;
	logic [ROW_W-1:0]   fill_row_q;
	logic [WIDE_W-1:0]  fill_base_q;    // fill_row_q * COLUMNS
	logic [WIDE_W-1:0]  fill_n_q;       // capped fill count
	logic               fill_status_q;

	// Decode
	logic               accept;
	logic               set_en, fill_start, tick_en, fill_en, fill_done;
	logic [WIDE_W-1:0]  idx_w, fill_n;
	logic [WIDE_W-1:0]  remain;         // shared subtractor output
	logic [COLUMNS-1:0] fill_mask;
	logic [COLUMNS-1:0] row_bits;

	assign idx_w  = WIDE_W'(index);
	assign fill_n = (idx_w > WIDE_W'(LED_COUNT)) ? WIDE_W'(LED_COUNT) : idx_w;

	// Remaining LEDs from the current fill row on; mask of columns to write
	assign remain = fill_n_q - fill_base_q;
	always_comb begin
		for (int t = 0; t < COLUMNS; t++) begin
			fill_mask[t] = WIDE_W'(t) < remain;
		end
	end
	assign fill_done = remain <= WIDE_W'(COLUMNS);

	// Row read for the drive phase
	assign row_bits = frame_q[scan_row_q * COLUMNS +: COLUMNS];

	assign accept = item_valid && !item_stall;

	// Sequencer: next state and decode
	always_comb begin
		state_d    = state_q;
		item_stall = 1'b0;
		set_en     = 1'b0;
		fill_start = 1'b0;
		tick_en    = 1'b0;
		fill_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// a tick must not overwrite a held result
				item_stall = result_valid_q && result_stall && (op_t'(opcode) == OP_TICK);
				if (item_valid && !item_stall) begin
					unique case (op_t'(opcode))
						OP_SET:  set_en  = idx_w < WIDE_W'(LED_COUNT);
						OP_FILL: begin
							fill_start = 1'b1;
							if (fill_n != '0) state_d = ST_FILL;
						end
						OP_TICK: tick_en = 1'b1;
						default: ;  // unused opcode: dropped
					endcase
				end
			end
			ST_FILL: begin
				item_stall = 1'b1;
				fill_en    = 1'b1;
				if (fill_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Fill operands, payload only
	always_ff @(posedge clk) begin
		if (fill_start) begin
			fill_n_q      <= fill_n;
			fill_status_q <= status;
			fill_row_q    <= '0;
			fill_base_q   <= '0;
		end else if (fill_en) begin
			fill_row_q    <= fill_row_q + ROW_W'(1);
			fill_base_q   <= fill_base_q + WIDE_W'(COLUMNS);
		end
	end

	// Frame store: single-LED set or one row of a fill per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else begin
			for (int i = 0; i < LED_COUNT; i++) begin
				if (set_en && idx_w == WIDE_W'(i)) begin
					frame_q[i] <= status;
				end
				if (fill_en && fill_row_q == ROW_W'(i / COLUMNS) && fill_mask[i % COLUMNS]) begin
					frame_q[i] <= fill_status_q;
				end
			end
		end
	end

	// Scan phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q     <= '0;
			scan_phase_q   <= 1'b0;
			row_lines_q    <= '0;
			column_lines_q <= '0;
		end else if (tick_en) begin
			if (!scan_phase_q) begin
				column_lines_q <= '0;
				scan_phase_q   <= 1'b1;
			end else begin
				row_lines_q    <= ROWS'(1) << scan_row_q;
				column_lines_q <= row_bits;
				scan_row_q     <= (scan_row_q == ROW_W'(ROWS - 1)) ? '0
				                  : scan_row_q + ROW_W'(1);
				scan_phase_q   <= 1'b0;
			end
		end
	end

	// Result beat holds the line registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (tick_en) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Lines past bit 9 are dropped, short matrices pad with zeros
	logic [LINE_W+15:0] row_wide, col_wide;
	assign row_wide     = (LINE_W + 16)'(row_lines_q);
	assign col_wide     = (LINE_W + 16)'(column_lines_q);
	assign row_select   = row_wide[LINE_W-1:0];
	assign column_drive = col_wide[LINE_W-1:0];
	assign result_valid = result_valid_q;

	// Checks
	a_row_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(row_lines_q))
		else $error("row select not one-hot");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, scan_row_q} < (ROW_W + 1)'(ROWS))
		else $error("scan row out of range");

	a_blank_clears: assert property (@(posedge clk) disable iff (!arst_n)
		tick_en && !scan_phase_q |=> column_lines_q == '0 && scan_phase_q)
		else $error("blanking tick left columns lit");

	a_fill_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> item_stall && !tick_en && !set_en)
		else $error("input taken during fill");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for led_matrix_scan_driver: directed table, then random beats.
// Depends on lmsd_pkg and the led_matrix_scan_driver RTL.
`timescale 1ns / 1ps

module tb;
	import lmsd_pkg::*;

	// Matrix geometry, matches the default parameters of the block
	localparam int unsigned ROWS    = 10;
	localparam int unsigned COLUMNS = 10;
	localparam int unsigned LEDS    = ROWS * COLUMNS;

	// Opcode 3 has no member in op_t; the block must ignore it
	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

	localparam int unsigned RANDOM_BEATS = 1950;
	localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int unsigned IDLE_LIMIT   = 5000;  // watchdog, cycles with no beat
	localparam int unsigned DRAIN_CYCLES = 20;    // settle time after the last result

	// One expected result beat
	typedef struct packed {
		logic [LINE_W-1:0] row_sel;
		logic [LINE_W-1:0] col_drv;
	} lines_t;

	// One row of the directed table; pinned rows carry a literal expectation
	typedef struct packed {
		logic [OPC_W-1:0]  opc;
		logic [IDX_W-1:0]  idx;
		logic              st;
		logic              pinned;
		logic [LINE_W-1:0] row_sel;
		logic [LINE_W-1:0] col_drv;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Input channel, known from time zero
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [OPC_W-1:0]  opcode = OP_SET;
	logic [IDX_W-1:0]  index = '0;
	logic              status = 1'b0;

	// Output channel
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [LINE_W-1:0] row_select;
	logic [LINE_W-1:0] column_drive;

	// Literal expectation travelling alongside the payload (testbench side only)
	logic              pin_en = 1'b0;
	logic [LINE_W-1:0] pin_row = '0;
	logic [LINE_W-1:0] pin_col = '0;

	// Shadow copy of the matrix state
	logic [LEDS-1:0]   led_frame;
	logic [ROW_W-1:0]  scan_row_q;
	logic              drive_next;   // 0: blanking phase comes next
	logic [LINE_W-1:0] row_lines_q;
	logic [LINE_W-1:0] col_lines_q;

	lines_t pending_lines [$];
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;

	// Traffic shaping shared by the sender and the receiver
	bit quiet = 1'b0;        // no gaps, no stalls
	bit hold_req = 1'b0;     // ask the receiver for one long hold-off
	bit hold_done = 1'b0;

	stim_row_t dir_tab [25] = '{
		// fresh out of reset: blanking, then drive row 0 of an empty store
		'{OP_TICK,   7'd0,   1'b0, 1'b1, 10'h000, 10'h000},
		'{OP_TICK,   7'd0,   1'b0, 1'b1, 10'h001, 10'h000},
		// last and first LED, then out-of-range positions
		'{OP_SET,    7'd99,  1'b1, 1'b0, 10'h000, 10'h000},
		'{OP_SET,    7'd0,   1'b1, 1'b0, 10'h000, 10'h000},
		'{OP_SET,    7'd100, 1'b1, 1'b0, 10'h000, 10'h000},
		'{OP_SET,    7'd127, 1'b1, 1'b0, 10'h000, 10'h000},
		// fill of zero, unused opcode
		'{OP_FILL,   7'd0,   1'b1, 1'b0, 10'h000, 10'h000},
		'{OP_UNUSED, 7'd127, 1'b1, 1'b0, 10'h000, 10'h000},
		// blanking keeps the row select, row 1 still dark
		'{OP_TICK,   7'd0,   1'b0, 1'b1, 10'h001, 10'h000},
		'{OP_TICK,   7'd0,   1'b0, 1'b1, 10'h002, 10'h000},
		// bar graph over row 0 and half of row 1
		'{OP_FILL,   7'd15,  1'b1, 1'b0, 10'h000, 10'h000},
		'{OP_TICK,   7'd0,   1'b0, 1'b1, 10'h002, 10'h000},
		'{OP_TICK,   7'd0,   1'b0, 1'b1, 10'h004, 10'h000},
		// oversized fill caps at the whole frame
		'{OP_FILL,   7'd127, 1'b1, 1'b0, 10'h000, 10'h000},
		'{OP_TICK,   7'd0,   1'b0, 1'b0, 10'h000, 10'h000},
		'{OP_TICK,   7'd0,   1'b0, 1'b1, 10'h008, 10'h3ff},
		// full dark fill, one LED on row 4
		'{OP_FILL,   7'd100, 1'b0, 1'b0, 10'h000, 10'h000},
		'{OP_SET,    7'd45,  1'b1, 1'b0, 10'h000, 10'h000},
		'{OP_UNUSED, 7'd0,   1'b0, 1'b0, 10'h000, 10'h000},
		'{OP_TICK,   7'd0,   1'b0, 1'b0, 10'h000, 10'h000},
		'{OP_TICK,   7'd0,   1'b0, 1'b1, 10'h010, 10'h020},
		// dark writes at both ends
		'{OP_FILL,   7'd1,   1'b0, 1'b0, 10'h000, 10'h000},
		'{OP_SET,    7'd99,  1'b0, 1'b0, 10'h000, 10'h000},
		'{OP_TICK,   7'd0,   1'b0, 1'b0, 10'h000, 10'h000},
		'{OP_TICK,   7'd0,   1'b0, 1'b0, 10'h000, 10'h000}
	};

	led_matrix_scan_driver #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.index        (index),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.row_select   (row_select),
		.column_drive (column_drive)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet)
			return 0;
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Positions and fill counts lean on the boundaries
	function automatic logic [IDX_W-1:0] pick_index();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd99;
			2: return 7'd100;
			3: return 7'd127;
			4: return 7'd1;
			default: return IDX_W'($urandom_range(0, 127));
		endcase
	endfunction

	function automatic void clear_matrix();
		led_frame   = '0;
		scan_row_q  = '0;
		drive_next  = 1'b0;
		row_lines_q = '0;
		col_lines_q = '0;
	endfunction

	// Apply one accepted beat to the shadow matrix; lit is set when a tick
	// produces a result beat
	function automatic void advance_matrix(input logic [OPC_W-1:0] opc,
			input logic [IDX_W-1:0] idx, input logic st,
			output logic lit, output lines_t lines);
		int unsigned n;
		int unsigned row;
		lit   = 1'b0;
		lines = '0;
		case (opc)
			OP_SET: begin
				if (idx < LEDS)
					led_frame[idx] = st;
			end
			OP_FILL: begin
				n = (idx > LEDS) ? LEDS : idx;
				for (int i = 0; i < LEDS; i++)
					if (i < n)
						led_frame[i] = st;
			end
			OP_TICK: begin
				if (!drive_next) begin
					// blanking: columns off, row select kept
					col_lines_q = '0;
					drive_next  = 1'b1;
				end else begin
					row = (scan_row_q >= ROWS) ? 0 : scan_row_q;
					row_lines_q = LINE_W'(1) << row;
					for (int t = 0; t < COLUMNS; t++)
						col_lines_q[t] = led_frame[row * COLUMNS + t];
					row = (row + 1 > ROWS - 1) ? 0 : row + 1;
					scan_row_q = ROW_W'(row);
					drive_next = 1'b0;
				end
				lit = 1'b1;
				lines.row_sel = row_lines_q;
				lines.col_drv = col_lines_q;
			end
			default: ;
		endcase
	endfunction

	// Offer one beat after a random gap and hold it until the block takes it.
	// Called at a rising edge; returns at the edge of acceptance.
	task automatic offer_beat(input logic [OPC_W-1:0] opc, input logic [IDX_W-1:0] idx,
			input logic st, input logic pinned, input lines_t lines);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		opcode     <= opc;
		index      <= idx;
		status     <= st;
		pin_en     <= pinned;
		pin_row    <= lines.row_sel;
		pin_col    <= lines.col_drv;
		do @(posedge clk); while (item_stall);
	endtask

	// Scoreboard: predict on accepted input beats, then check accepted results.
	// Both happen in one process so the queue order never depends on scheduling.
	always @(posedge clk) begin
		logic   lit;
		lines_t lines;
		lines_t want;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				advance_matrix(opcode, index, status, lit, lines);
				if (lit) begin
					if (pin_en) begin
						lines.row_sel = pin_row;
						lines.col_drv = pin_col;
					end
					pending_lines.push_back(lines);
				end
			end
			if (result_valid && !result_stall) begin
				if (pending_lines.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat row_select=%h column_drive=%h",
						$time, row_select, column_drive);
				end else begin
					want = pending_lines.pop_front();
					if (row_select !== want.row_sel) begin
						mismatches++;
						$display("%0t: row_select expected %h actual %h",
							$time, want.row_sel, row_select);
					end
					if (column_drive !== want.col_drv) begin
						mismatches++;
						$display("%0t: column_drive expected %h actual %h",
							$time, want.col_drv, column_drive);
					end
				end
			end
		end
	end

	// Receiver: random stalls, one long hold-off on request, none when quiet
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				// the sender keeps offering beats; the block has to back up
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (quiet) begin
				result_stall <= 1'b0;
				stall_left = 0;
			end else if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
				if ($urandom_range(0, 99) < 30)
					stall_left = pick_gap();
			end
		end
	end

	// Watchdog: too long with no beat on either side ends the run
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding",
				$time, pending_lines.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int unsigned counted;
		int unsigned burst;
		int unsigned r;
		logic [OPC_W-1:0] opc;
		logic [IDX_W-1:0] idx;
		counted = 0;
		burst   = 0;
		clear_matrix();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table
		foreach (dir_tab[i])
			offer_beat(dir_tab[i].opc, dir_tab[i].idx, dir_tab[i].st, dir_tab[i].pinned,
				lines_t'{row_sel: dir_tab[i].row_sel, col_drv: dir_tab[i].col_drv});

		// Random beats, opcode 3 mixed in as noise
		while (counted < RANDOM_BEATS) begin
			quiet = (counted >= 600 && counted < 800);
			if (counted == 1000)
				hold_req = 1'b1;
			// now and then a run of ticks to sweep every row and the wrap
			if (burst == 0 && $urandom_range(0, 99) < 3)
				burst = $urandom_range(10, 30);
			r = $urandom_range(0, 99);
			if (burst > 0) begin
				opc = OP_TICK;
				burst--;
			end else if (r < 40)
				opc = OP_TICK;
			else if (r < 70)
				opc = OP_SET;
			else if (r < 94)
				opc = OP_FILL;
			else
				opc = OP_UNUSED;
			idx = pick_index();
			offer_beat(opc, idx, 1'($urandom_range(0, 1)), 1'b0, '0);
			counted++;
		end
		item_valid <= 1'b0;
		quiet = 1'b0;

		// Drain, then give stray beats a chance to show up
		while (pending_lines.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_lines.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
